// ===== hdl/rc4_pkg.sv =====
// Shared types and constants for the RC4 stream cipher core.
// Used by the controller, the datapath and the top level; no dependencies.
package rc4_pkg;

    // Default key store depth and the key length after reset.
    localparam int MAX_KEY_BYTES_DEF = 256;
    localparam logic [8:0] KEY_LEN_RESET = 9'd16;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_LOAD_KEY = 2'd0;
    localparam logic [1:0] KIND_SCHEDULE = 2'd1;
    localparam logic [1:0] KIND_DATA     = 2'd2;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_READ,
        ST_KS_MIX,
        ST_KS_WR_N,
        ST_KS_WR_J,
        ST_GEN_READ_J,
        ST_GEN_SWAP,
        ST_GEN_OUT
    } t_state;

    // Datapath operations issued by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_KEY,
        OP_KS_INIT,
        OP_KS_READ,
        OP_KS_MIX,
        OP_KS_WR_N,
        OP_KS_WR_J,
        OP_GEN_START,
        OP_GEN_READ_J,
        OP_GEN_SWAP,
        OP_GEN_OUT
    } t_dp_op;

    // Status returned by the datapath.
    typedef struct packed {
        logic ks_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/rc4_ctrl.sv =====
// Controller state machine for the RC4 core: sequences key loads, the key
// schedule and keystream steps. Depends on rc4_pkg.
module rc4_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_kind,
    input  rc4_pkg::t_dp_status i_status,
    output logic               o_in_stall,
    output rc4_pkg::t_dp_op    o_op
);
    import rc4_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath command.
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_LOAD_KEY: begin
                            o_op = OP_LOAD_KEY;
                        end
                        KIND_SCHEDULE: begin
                            o_op    = OP_KS_INIT;
                            n_state = ST_KS_READ;
                        end
                        KIND_DATA: begin
                            o_op    = OP_GEN_START;
                            n_state = ST_GEN_READ_J;
                        end
                        default: begin
                            o_op = OP_NONE;
                        end
                    endcase
                end
            end
            ST_KS_READ: begin
                o_op    = OP_KS_READ;
                n_state = ST_KS_MIX;
            end
            ST_KS_MIX: begin
                o_op    = OP_KS_MIX;
                n_state = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                o_op    = OP_KS_WR_N;
                n_state = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                o_op    = OP_KS_WR_J;
                n_state = i_status.ks_last ? ST_IDLE : ST_KS_READ;
            end
            ST_GEN_READ_J: begin
                o_op    = OP_GEN_READ_J;
                n_state = ST_GEN_SWAP;
            end
            ST_GEN_SWAP: begin
                o_op    = OP_GEN_SWAP;
                n_state = ST_GEN_OUT;
            end
            ST_GEN_OUT: begin
                // Hold here until the output register can take the beat.
                if (i_status.out_free) begin
                    o_op    = OP_GEN_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== hdl/rc4_datapath.sv =====
// Datapath for the RC4 core: S-box and key store memories, indices, the
// schedule accumulator and the output register. Depends on rc4_pkg.
module rc4_datapath #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rc4_pkg::t_dp_op     i_op,
    input  logic [7:0]          i_key_index,
    input  logic [7:0]          i_key_byte,
    input  logic [7:0]          i_data_byte,
    input  logic                i_cfg_wr_en,
    input  logic [8:0]          i_cfg_wr_data,
    input  logic                i_out_stall,
    output rc4_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output logic [7:0]          o_cipher_byte,
    output logic [7:0]          o_keystream_byte
);
    import rc4_pkg::*;

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [8:0] MAX_LEN = 9'(MAX_KEY_BYTES);

    // Configuration and indices.
    logic [8:0]        r_key_len;
    logic [7:0]        r_i;
    logic [7:0]        r_j;
    logic [7:0]        r_n;
    logic [KEY_AW-1:0] r_k;
    logic [7:0]        r_acc;
    logic [7:0]        r_si;
    logic [7:0]        r_sj;
    logic [7:0]        r_t;
    logic [7:0]        r_data;

    // S-box memory with per-entry valid bits; an invalid entry reads as its index.
    logic [7:0]   r_sbox [256];
    logic [255:0] r_sv;
    logic [7:0]   r_rd_mem;
    logic         r_rd_v;
    logic [7:0]   r_rd_addr;
    logic [7:0]   s_rd;

    // Key store memory.
    logic [7:0]   r_key [MAX_KEY_BYTES];
    logic [7:0]   r_kb;

    // Output register.
    logic         r_out_valid;
    logic [7:0]   r_cipher;
    logic [7:0]   r_ks;

    // Memory port controls.
    logic         s_re;
    logic [7:0]   s_ra;
    logic         s_we;
    logic [7:0]   s_wa;
    logic [7:0]   s_wd;
    logic         s_kre;
    logic         s_kwe;

    logic [8:0]   s_eff_len;
    logic [7:0]   s_acc_new;
    logic [7:0]   s_ks;
    logic         s_k_wrap;

    assign s_rd = r_rd_v ? r_rd_mem : r_rd_addr;

    // Effective key length, saturated to the valid range.
    always_comb begin
        if (r_key_len == 9'd0) begin
            s_eff_len = 9'd1;
        end else if (r_key_len > MAX_LEN) begin
            s_eff_len = MAX_LEN;
        end else begin
            s_eff_len = r_key_len;
        end
    end

    assign s_k_wrap  = ({{(9 - KEY_AW){1'b0}}, r_k} == (s_eff_len - 9'd1));
    assign s_acc_new = r_acc + r_kb + s_rd;

    // Keystream byte after the swap: forward the two freshly swapped entries.
    always_comb begin
        if (r_t == r_j) begin
            s_ks = r_si;
        end else if (r_t == r_i) begin
            s_ks = r_sj;
        end else begin
            s_ks = s_rd;
        end
    end

    // Memory port selection per operation.
    always_comb begin
        s_re  = 1'b0;
        s_ra  = 8'd0;
        s_we  = 1'b0;
        s_wa  = 8'd0;
        s_wd  = 8'd0;
        s_kre = 1'b0;
        s_kwe = 1'b0;
        case (i_op)
            OP_LOAD_KEY: begin
                s_kwe = ({1'b0, i_key_index} < MAX_LEN);
            end
            OP_KS_READ: begin
                s_re  = 1'b1;
                s_ra  = r_n;
                s_kre = 1'b1;
            end
            OP_KS_MIX: begin
                s_re = 1'b1;
                s_ra = s_acc_new;
            end
            OP_KS_WR_N: begin
                s_we = 1'b1;
                s_wa = r_n;
                s_wd = s_rd;
            end
            OP_KS_WR_J: begin
                s_we = 1'b1;
                s_wa = r_acc;
                s_wd = r_si;
            end
            OP_GEN_START: begin
                s_re = 1'b1;
                s_ra = r_i + 8'd1;
            end
            OP_GEN_READ_J: begin
                s_re = 1'b1;
                s_ra = r_j + s_rd;
            end
            OP_GEN_SWAP: begin
                s_re = 1'b1;
                s_ra = r_si + s_rd;
                s_we = 1'b1;
                s_wa = r_i;
                s_wd = s_rd;
            end
            OP_GEN_OUT: begin
                s_we = 1'b1;
                s_wa = r_j;
                s_wd = r_si;
            end
            default: begin
                s_re = 1'b0;
            end
        endcase
    end

    // S-box storage and registered read.
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_sbox[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_rd_mem  <= r_sbox[s_ra];
            r_rd_addr <= s_ra;
        end
    end

    // S-box valid bits, cleared by reset and at the start of a schedule.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_op == OP_KS_INIT)) begin
            r_sv   <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (s_re) begin
                r_rd_v <= r_sv[s_ra];
            end
            if (s_we) begin
                r_sv[s_wa] <= 1'b1;
            end
        end
    end

    // Key store and its registered read.
    always_ff @(posedge i_clk) begin
        if (s_kwe) begin
            r_key[i_key_index[KEY_AW-1:0]] <= i_key_byte;
        end
        if (s_kre) begin
            r_kb <= r_key[r_k];
        end
    end

    // Key length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_key_len <= i_cfg_wr_data;
        end
    end

    // Generator indices, cleared at reset and at the end of a schedule.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= 8'd0;
            r_j <= 8'd0;
        end else begin
            case (i_op)
                OP_GEN_START: begin
                    r_i <= r_i + 8'd1;
                end
                OP_GEN_READ_J: begin
                    r_j <= r_j + s_rd;
                end
                OP_KS_WR_J: begin
                    if (r_n == 8'hFF) begin
                        r_i <= 8'd0;
                        r_j <= 8'd0;
                    end
                end
                default: begin
                    r_i <= r_i;
                end
            endcase
        end
    end

    // Schedule and generator working registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_KS_INIT: begin
                r_n   <= 8'd0;
                r_k   <= '0;
                r_acc <= 8'd0;
            end
            OP_KS_MIX: begin
                r_acc <= s_acc_new;
                r_si  <= s_rd;
            end
            OP_KS_WR_J: begin
                r_n <= r_n + 8'd1;
                r_k <= s_k_wrap ? '0 : r_k + 1'b1;
            end
            OP_GEN_START: begin
                r_data <= i_data_byte;
            end
            OP_GEN_READ_J: begin
                r_si <= s_rd;
            end
            OP_GEN_SWAP: begin
                r_sj <= s_rd;
                r_t  <= r_si + s_rd;
            end
            default: begin
                r_n <= r_n;
            end
        endcase
    end

    // Output register: loaded at the end of a generator step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_op == OP_GEN_OUT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_GEN_OUT) begin
            r_ks     <= s_ks;
            r_cipher <= r_data ^ s_ks;
        end
    end

    assign o_status = '{ks_last: (r_n == 8'hFF), out_free: (!r_out_valid || !i_out_stall)};
    assign o_out_valid       = r_out_valid;
    assign o_cipher_byte     = r_cipher;
    assign o_keystream_byte  = r_ks;

endmodule

// ===== hdl/rc4_stream_cipher_core.sv =====
// RC4 stream cipher core: top level joining the controller and the datapath.
// Depends on rc4_pkg, rc4_ctrl and rc4_datapath.
//
// The core takes one item at a time. A key-load item is taken without leaving
// the idle state. A data item passes through the read-j, swap and output states
// until its beat sits in the output register. Its steps use the S-box memory,
// with one read and one write port: read S[i], read S[j], write S[i] while
// reading the keystream entry, then write S[j]; a stalled output beat holds the
// last step. A schedule item runs 256 steps after its acceptance, each a read,
// a mix and two swap writes. The S-box returns to the identity through
// per-entry valid bits, cleared at reset and at the start of every schedule,
// so no clearing pass is needed. The key length register is to be written
// only while the core is idle: a rule for the user, not enforced by the core.
module rc4_stream_cipher_core #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_key_index,
    input  logic [7:0] i_key_byte,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_cipher_byte,
    output logic [7:0] o_keystream_byte,
    input  logic       i_cfg_wr_en,
    input  logic [8:0] i_cfg_wr_data
);
    import rc4_pkg::*;

    t_dp_op     s_op;
    t_dp_status s_status;

    // Sequencer.
    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (s_status),
        .o_in_stall (o_in_stall),
        .o_op       (s_op)
    );

    // Storage and arithmetic.
    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (s_op),
        .i_key_index      (i_key_index),
        .i_key_byte       (i_key_byte),
        .i_data_byte      (i_data_byte),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_out_stall      (i_out_stall),
        .o_status         (s_status),
        .o_out_valid      (o_out_valid),
        .o_cipher_byte    (o_cipher_byte),
        .o_keystream_byte (o_keystream_byte)
    );

endmodule
